### hdl/tphc_pkg.sv
// ============================================================================
// tphc_pkg
// Shared types and constants of the temperature / pressure / humidity
// compensation block.
// ============================================================================
package tphc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_CALIB = 3'd0,
        REG_PRESS_LO   = 3'd1,
        REG_PRESS_HI   = 3'd2,
        REG_HUM_LO     = 3'd3,
        REG_HUM_HI     = 3'd4
    } t_reg_index;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Divider: 64-bit dividend, one quotient bit per stage
    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = DIV_W;
    localparam int DEN_W     = 31;

    // Formula constants
    localparam logic signed [33:0] P_TFINE_OFS   = 34'sd128000;
    localparam logic [20:0]        P_ADC_FULL    = 21'd1048576;
    localparam logic [63:0]        P_NUM_SCALE   = 64'd3125;
    localparam logic signed [63:0] P_DEN_BIAS    = 64'sh0000_8000_0000_0000;
    localparam logic signed [31:0] H_TFINE_OFS   = 32'sd76800;
    localparam logic signed [31:0] H_RND_A       = 32'sd16384;
    localparam logic signed [31:0] H_OFS_B       = 32'sd32768;
    localparam logic signed [31:0] H_OFS_C       = 32'sd2097152;
    localparam logic signed [31:0] H_RND_D       = 32'sd8192;
    localparam logic signed [31:0] H_CLAMP_MAX   = 32'sd419430400;
    localparam logic signed [31:0] T_RND         = 32'sd128;

    // Unpacked calibration coefficients
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } t_calib;

    // Item as classified by the front part
    typedef struct packed {
        logic signed [17:0] ta;     // (adc_t >> 3) - (t1 << 1)
        logic signed [16:0] td;     // (adc_t >> 4) - t1
        logic        [19:0] adc_p;
        logic        [15:0] adc_h;
    } t_item;

    // Values carried alongside the divider
    typedef struct packed {
        logic signed [31:0] tf;
        logic signed [31:0] tc;
        logic signed [31:0] ha;
        logic signed [31:0] hb;
    } t_side;

endpackage

### hdl/tphc_front.sv
// ============================================================================
// tphc_front
// Calibration registers and input stage: captures a raw triple, forms the
// first temperature differences and hands the item to the queue.
// ============================================================================
module tphc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [19:0]                       i_raw_temperature,
    input  logic [19:0]                       i_raw_pressure,
    input  logic [15:0]                       i_raw_humidity,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tphc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tphc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tphc_pkg::t_calib                  o_calib,
    output logic                              o_q_push,
    output tphc_pkg::t_item                   o_q_item,
    input  logic                              i_q_full
);
    import tphc_pkg::*;

    logic [47:0] r_temp_calib;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [47:0] r_hum_lo;
    logic [31:0] r_hum_hi;

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_lo   <= '0;
            r_press_hi   <= '0;
            r_hum_lo     <= '0;
            r_hum_hi     <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_index'(i_cfg_index))
                REG_TEMP_CALIB: r_temp_calib <= i_cfg_data[47:0];
                REG_PRESS_LO:   r_press_lo   <= i_cfg_data;
                REG_PRESS_HI:   r_press_hi   <= i_cfg_data;
                REG_HUM_LO:     r_hum_lo     <= i_cfg_data[47:0];
                REG_HUM_HI:     r_hum_hi     <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Coefficient unpacking
    always_comb begin
        o_calib.t1 = r_temp_calib[15:0];
        o_calib.t2 = r_temp_calib[31:16];
        o_calib.t3 = r_temp_calib[47:32];
        o_calib.p1 = r_press_lo[15:0];
        o_calib.p2 = r_press_lo[31:16];
        o_calib.p3 = r_press_lo[47:32];
        o_calib.p4 = r_press_lo[63:48];
        o_calib.p5 = r_press_hi[15:0];
        o_calib.p6 = r_press_hi[31:16];
        o_calib.p7 = r_press_hi[47:32];
        o_calib.p8 = r_press_hi[63:48];
        o_calib.p9 = r_hum_lo[15:0];
        o_calib.h1 = r_hum_lo[23:16];
        o_calib.h2 = r_hum_lo[39:24];
        o_calib.h3 = r_hum_lo[47:40];
        o_calib.h4 = r_hum_hi[11:0];
        o_calib.h5 = r_hum_hi[23:12];
        o_calib.h6 = r_hum_hi[31:24];
    end

    // Classify: first temperature differences
    always_comb begin
        n_item.ta    = $signed({1'b0, i_raw_temperature[19:3]})
                     - $signed({1'b0, o_calib.t1, 1'b0});
        n_item.td    = $signed({1'b0, i_raw_temperature[19:4]})
                     - $signed({1'b0, o_calib.t1});
        n_item.adc_p = i_raw_pressure;
        n_item.adc_h = i_raw_humidity;
    end

    // Input stage, drained into the queue
    assign o_full   = r_vld & i_q_full;
    assign w_accept = i_push & ~o_full;
    assign o_q_push = r_vld & ~i_q_full;
    assign o_q_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_accept | (r_vld & i_q_full);
        end
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/tphc_queue.sv
// ============================================================================
// tphc_queue
// Short first-in first-out queue of classified items between the front
// and the back.
// ============================================================================
module tphc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tphc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tphc_pkg::t_item o_item
);
    import tphc_pkg::*;

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/tphc_div.sv
// ============================================================================
// tphc_div
// Pipelined signed divider: 64-bit dividend by 31-bit divisor, one
// restoring step per stage, quotient truncated toward zero.
// ============================================================================
module tphc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [tphc_pkg::DIV_W-1:0]    i_num,
    input  logic [tphc_pkg::DEN_W-1:0]    i_den,
    input  tphc_pkg::t_side               i_side,
    output logic                          o_valid,
    output logic [tphc_pkg::DIV_W-1:0]    o_quot,
    output logic                          o_dz,
    output tphc_pkg::t_side               o_side
);
    import tphc_pkg::*;

    logic             r_vld  [DIV_STEPS+1];
    logic [DIV_W-1:0] r_n    [DIV_STEPS+1];
    logic [DEN_W-1:0] r_rem  [DIV_STEPS+1];
    logic [DEN_W-1:0] r_ud   [DIV_STEPS+1];
    logic             r_neg  [DIV_STEPS+1];
    logic             r_dz   [DIV_STEPS+1];
    t_side            r_side [DIV_STEPS+1];

    logic [DIV_W-1:0] w_num_abs;
    logic [DEN_W-1:0] w_den_abs;

    logic             r_out_vld;
    logic [DIV_W-1:0] r_quot;
    logic             r_out_dz;
    t_side            r_out_side;

    // Stage 0: magnitudes and result sign
    assign w_num_abs = i_num[DIV_W-1] ? (DIV_W'(0) - i_num) : i_num;
    assign w_den_abs = i_den[DEN_W-1] ? (DEN_W'(0) - i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
        if (i_en) begin
            r_n[0]    <= w_num_abs;
            r_rem[0]  <= '0;
            r_ud[0]   <= w_den_abs;
            r_neg[0]  <= i_num[DIV_W-1] ^ i_den[DEN_W-1];
            r_dz[0]   <= (i_den == '0);
            r_side[0] <= i_side;
        end
    end

    // Restoring steps; quotient bits shift in behind the dividend
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [DEN_W:0] w_trial;
        logic           w_ge;

        assign w_trial = {r_rem[k-1], r_n[k-1][DIV_W-1]};
        assign w_ge    = (w_trial >= {1'b0, r_ud[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_en) begin
                r_n[k]    <= {r_n[k-1][DIV_W-2:0], w_ge};
                r_rem[k]  <= w_ge ? DEN_W'(w_trial - {1'b0, r_ud[k-1]})
                                  : w_trial[DEN_W-1:0];
                r_ud[k]   <= r_ud[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_dz[k]   <= r_dz[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Sign correction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[DIV_STEPS];
        end
        if (i_en) begin
            r_quot     <= r_neg[DIV_STEPS] ? (DIV_W'(0) - r_n[DIV_STEPS])
                                           : r_n[DIV_STEPS];
            r_out_dz   <= r_dz[DIV_STEPS];
            r_out_side <= r_side[DIV_STEPS];
        end
    end

    assign o_valid = r_out_vld;
    assign o_quot  = r_quot;
    assign o_dz    = r_out_dz;
    assign o_side  = r_out_side;

endmodule

### hdl/tphc_back.sv
// ============================================================================
// tphc_back
// Compensation pipeline: temperature, pressure (with the divider) and
// humidity, ending in the result register.
// ============================================================================
module tphc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tphc_pkg::t_calib   i_calib,
    input  logic               i_q_empty,
    input  tphc_pkg::t_item    i_q_item,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [31:0] o_fine_temperature,
    output logic signed [31:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_pressure_divisor_zero,
    output logic [16:0]        o_humidity_q22_10
);
    import tphc_pkg::*;

    // Coefficients as signed values
    logic signed [31:0] c_t2, c_t3;
    logic signed [63:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;
    logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

    assign c_t2 = 32'($signed(i_calib.t2));
    assign c_t3 = 32'($signed(i_calib.t3));
    assign c_p1 = $signed({48'd0, i_calib.p1});
    assign c_p2 = 64'($signed(i_calib.p2));
    assign c_p3 = 64'($signed(i_calib.p3));
    assign c_p4 = 64'($signed(i_calib.p4));
    assign c_p5 = 64'($signed(i_calib.p5));
    assign c_p6 = 64'($signed(i_calib.p6));
    assign c_p7 = 64'($signed(i_calib.p7));
    assign c_p8 = 64'($signed(i_calib.p8));
    assign c_p9 = 64'($signed(i_calib.p9));
    assign c_h1 = $signed({24'd0, i_calib.h1});
    assign c_h2 = 32'($signed(i_calib.h2));
    assign c_h3 = $signed({24'd0, i_calib.h3});
    assign c_h4 = 32'($signed(i_calib.h4));
    assign c_h5 = 32'($signed(i_calib.h5));
    assign c_h6 = 32'($signed(i_calib.h6));

    // Whole pipeline moves when the result register is free or taken
    logic r_out_vld;
    logic w_adv;

    assign w_adv   = ~r_out_vld | i_pop;
    assign o_q_pop = w_adv & ~i_q_empty;
    assign o_empty = ~r_out_vld;

    // Stage valids
    logic r_b1_vld, r_b2_vld, r_b3_vld, r_b4_vld, r_b5_vld;
    logic r_b6_vld, r_b7_vld, r_b8_vld, r_b9_vld;
    logic r_p1_vld, r_p2_vld, r_p3_vld;
    logic w_div_vld;

    // Stage registers
    logic signed [31:0] r_b1_ma, r_b1_dd;
    logic [19:0]        r_b1_adc_p, r_b2_adc_p, r_b3_adc_p, r_b4_adc_p;
    logic [19:0]        r_b5_adc_p, r_b6_adc_p, r_b7_adc_p;
    logic [15:0]        r_b1_adc_h, r_b2_adc_h, r_b3_adc_h, r_b4_adc_h;
    logic signed [20:0] r_b2_va;
    logic signed [31:0] r_b2_mb;
    logic signed [31:0] r_b3_tf, r_b4_tf, r_b5_tf, r_b6_tf, r_b7_tf;
    logic signed [31:0] r_b8_tf, r_b9_tf;
    logic signed [31:0] r_b4_tc, r_b5_tc, r_b6_tc, r_b7_tc, r_b8_tc, r_b9_tc;
    logic signed [33:0] r_b4_v1;
    logic signed [31:0] r_b4_x;
    logic signed [63:0] r_b5_sq;
    logic signed [49:0] r_b5_m5, r_b5_m2, r_b6_m5, r_b6_m2;
    logic signed [31:0] r_b5_mh5, r_b5_mh6, r_b5_mh3, r_b5_base;
    logic signed [63:0] r_b6_sq6, r_b6_sq3;
    logic signed [31:0] r_b6_ha, r_b6_f6, r_b6_f3;
    logic signed [63:0] r_b7_v2, r_b7_u;
    logic signed [31:0] r_b7_ha, r_b7_inner;
    logic signed [63:0] r_b8_up;
    logic [63:0]        r_b8_num0;
    logic signed [31:0] r_b8_ha, r_b8_hbm;
    logic [63:0]        r_b9_num;
    logic [DEN_W-1:0]   r_b9_den;
    logic signed [31:0] r_b9_ha, r_b9_hb;

    logic signed [63:0] w_b5_v1;
    logic signed [63:0] w_b8_up_sh;
    logic [20:0]        w_b8_pd;
    t_side              w_div_side_in;

    logic [63:0]        w_div_quot;
    logic               w_div_dz;
    t_side              w_div_side;

    logic signed [63:0] r_p1_p, r_p1_p9q, r_p1_w2m;
    logic               r_p1_dz, r_p2_dz, r_p3_dz;
    logic signed [31:0] r_p1_tf, r_p2_tf, r_p3_tf;
    logic signed [31:0] r_p1_tc, r_p2_tc, r_p3_tc;
    logic signed [31:0] r_p1_v, r_p2_v, r_p3_v;
    logic [63:0]        r_p2_pp0;
    logic [31:0]        r_p2_pp1, r_p2_pp2;
    logic signed [63:0] r_p2_sa;
    logic signed [31:0] r_p2_ss;
    logic signed [63:0] r_p3_sum;
    logic signed [31:0] r_p3_hh;

    logic signed [63:0] w_p1_q13, w_p2_q13;
    logic signed [31:0] w_p2_s;
    logic [63:0]        w_p3_prod;
    logic signed [63:0] w_p3_w1;
    logic signed [31:0] w_out_pres;
    logic signed [31:0] w_out_hv;
    logic [16:0]        w_out_hum;

    logic signed [31:0] r_out_tf, r_out_tc;
    logic [31:0]        r_out_pres;
    logic               r_out_dz;
    logic [16:0]        r_out_hum;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld  <= 1'b0;
            r_b2_vld  <= 1'b0;
            r_b3_vld  <= 1'b0;
            r_b4_vld  <= 1'b0;
            r_b5_vld  <= 1'b0;
            r_b6_vld  <= 1'b0;
            r_b7_vld  <= 1'b0;
            r_b8_vld  <= 1'b0;
            r_b9_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_b1_vld  <= ~i_q_empty;
            r_b2_vld  <= r_b1_vld;
            r_b3_vld  <= r_b2_vld;
            r_b4_vld  <= r_b3_vld;
            r_b5_vld  <= r_b4_vld;
            r_b6_vld  <= r_b5_vld;
            r_b7_vld  <= r_b6_vld;
            r_b8_vld  <= r_b7_vld;
            r_b9_vld  <= r_b8_vld;
            r_p1_vld  <= w_div_vld;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_out_vld <= r_p3_vld;
        end
    end

    // Temperature: stages 1 to 4
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // products of the first differences
            r_b1_ma    <= 32'(i_q_item.ta) * c_t2;
            r_b1_dd    <= 32'(i_q_item.td) * 32'(i_q_item.td);
            r_b1_adc_p <= i_q_item.adc_p;
            r_b1_adc_h <= i_q_item.adc_h;
            // var1 and second product
            r_b2_va    <= 21'(r_b1_ma >>> 11);
            r_b2_mb    <= (r_b1_dd >>> 12) * c_t3;
            r_b2_adc_p <= r_b1_adc_p;
            r_b2_adc_h <= r_b1_adc_h;
            // fine temperature
            r_b3_tf    <= 32'(r_b2_va) + (r_b2_mb >>> 14);
            r_b3_adc_p <= r_b2_adc_p;
            r_b3_adc_h <= r_b2_adc_h;
            // centi-degrees and offsets for the other paths
            r_b4_tc    <= ((r_b3_tf <<< 2) + r_b3_tf + T_RND) >>> 8;
            r_b4_v1    <= 34'(r_b3_tf) - P_TFINE_OFS;
            r_b4_x     <= r_b3_tf - H_TFINE_OFS;
            r_b4_tf    <= r_b3_tf;
            r_b4_adc_p <= r_b3_adc_p;
            r_b4_adc_h <= r_b3_adc_h;
        end
    end

    // Pressure and humidity before the divider: stages 5 to 9
    assign w_b5_v1    = 64'(r_b4_v1);
    assign w_b8_up_sh = r_b8_up >>> 33;
    assign w_b8_pd    = P_ADC_FULL - {1'b0, r_b7_adc_p};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 5: var1 products, humidity products
            r_b5_sq    <= w_b5_v1 * w_b5_v1;
            r_b5_m5    <= 50'(r_b4_v1) * 50'(c_p5);
            r_b5_m2    <= 50'(r_b4_v1) * 50'(c_p2);
            r_b5_mh5   <= r_b4_x * c_h5;
            r_b5_mh6   <= r_b4_x * c_h6;
            r_b5_mh3   <= r_b4_x * c_h3;
            r_b5_base  <= $signed({2'b00, r_b4_adc_h, 14'd0}) - (c_h4 <<< 20);
            r_b5_tf    <= r_b4_tf;
            r_b5_tc    <= r_b4_tc;
            r_b5_adc_p <= r_b4_adc_p;
            // stage 6
            r_b6_sq6   <= r_b5_sq * c_p6;
            r_b6_sq3   <= r_b5_sq * c_p3;
            r_b6_m5    <= r_b5_m5;
            r_b6_m2    <= r_b5_m2;
            r_b6_ha    <= (r_b5_base - r_b5_mh5 + H_RND_A) >>> 15;
            r_b6_f6    <= r_b5_mh6 >>> 10;
            r_b6_f3    <= (r_b5_mh3 >>> 11) + H_OFS_B;
            r_b6_tf    <= r_b5_tf;
            r_b6_tc    <= r_b5_tc;
            r_b6_adc_p <= r_b5_adc_p;
            // stage 7: var2 and biased var1
            r_b7_v2    <= r_b6_sq6 + (64'(r_b6_m5) <<< 17) + (c_p4 <<< 35);
            r_b7_u     <= P_DEN_BIAS + (r_b6_sq3 >>> 8) + (64'(r_b6_m2) <<< 12);
            r_b7_ha    <= r_b6_ha;
            r_b7_inner <= r_b6_f6 * r_b6_f3;
            r_b7_tf    <= r_b6_tf;
            r_b7_tc    <= r_b6_tc;
            r_b7_adc_p <= r_b6_adc_p;
            // stage 8
            r_b8_up    <= r_b7_u * c_p1;
            r_b8_num0  <= {12'd0, w_b8_pd, 31'd0} - r_b7_v2;
            r_b8_ha    <= r_b7_ha;
            r_b8_hbm   <= ((r_b7_inner >>> 10) + H_OFS_C) * c_h2;
            r_b8_tf    <= r_b7_tf;
            r_b8_tc    <= r_b7_tc;
            // stage 9: dividend and divisor
            r_b9_num   <= r_b8_num0 * P_NUM_SCALE;
            r_b9_den   <= w_b8_up_sh[DEN_W-1:0];
            r_b9_ha    <= r_b8_ha;
            r_b9_hb    <= (r_b8_hbm + H_RND_D) >>> 14;
            r_b9_tf    <= r_b8_tf;
            r_b9_tc    <= r_b8_tc;
        end
    end

    // Divider
    always_comb begin
        w_div_side_in.tf = r_b9_tf;
        w_div_side_in.tc = r_b9_tc;
        w_div_side_in.ha = r_b9_ha;
        w_div_side_in.hb = r_b9_hb;
    end

    tphc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_b9_vld),
        .i_num   (r_b9_num),
        .i_den   (r_b9_den),
        .i_side  (w_div_side_in),
        .o_valid (w_div_vld),
        .o_quot  (w_div_quot),
        .o_dz    (w_div_dz),
        .o_side  (w_div_side)
    );

    // After the divider: stages P1 to P3
    assign w_p1_q13  = $signed(w_div_quot) >>> 13;
    assign w_p2_q13  = r_p1_p >>> 13;
    assign w_p2_s    = r_p1_v >>> 15;
    assign w_p3_prod = r_p2_pp0 + {r_p2_pp1 + r_p2_pp2, 32'd0};
    assign w_p3_w1   = $signed(w_p3_prod) >>> 25;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // P1
            r_p1_p   <= $signed(w_div_quot);
            r_p1_p9q <= c_p9 * w_p1_q13;
            r_p1_w2m <= c_p8 * $signed(w_div_quot);
            r_p1_v   <= w_div_side.ha * w_div_side.hb;
            r_p1_dz  <= w_div_dz;
            r_p1_tf  <= w_div_side.tf;
            r_p1_tc  <= w_div_side.tc;
            // P2: partial products of the square term
            r_p2_pp0 <= {32'd0, r_p1_p9q[31:0]} * {32'd0, w_p2_q13[31:0]};
            r_p2_pp1 <= r_p1_p9q[63:32] * w_p2_q13[31:0];
            r_p2_pp2 <= r_p1_p9q[31:0] * w_p2_q13[63:32];
            r_p2_sa  <= r_p1_p + (r_p1_w2m >>> 19);
            r_p2_ss  <= w_p2_s * w_p2_s;
            r_p2_v   <= r_p1_v;
            r_p2_dz  <= r_p1_dz;
            r_p2_tf  <= r_p1_tf;
            r_p2_tc  <= r_p1_tc;
            // P3
            r_p3_sum <= r_p2_sa + w_p3_w1;
            r_p3_hh  <= (r_p2_ss >>> 7) * c_h1;
            r_p3_v   <= r_p2_v;
            r_p3_dz  <= r_p2_dz;
            r_p3_tf  <= r_p2_tf;
            r_p3_tc  <= r_p2_tc;
        end
    end

    // Final pressure and humidity clamp
    always_comb begin
        w_out_pres = 32'(r_p3_sum >>> 8) + 32'(c_p7 <<< 4);
        w_out_hv   = r_p3_v - (r_p3_hh >>> 4);
        if (w_out_hv[31]) begin
            w_out_hum = '0;
        end else if (w_out_hv > H_CLAMP_MAX) begin
            w_out_hum = H_CLAMP_MAX[28:12];
        end else begin
            w_out_hum = w_out_hv[28:12];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_tf   <= r_p3_tf;
            r_out_tc   <= r_p3_tc;
            r_out_pres <= r_p3_dz ? 32'd0 : w_out_pres;
            r_out_dz   <= r_p3_dz;
            r_out_hum  <= w_out_hum;
        end
    end

    assign o_fine_temperature      = r_out_tf;
    assign o_temperature_centi     = r_out_tc;
    assign o_pressure_q24_8        = r_out_pres;
    assign o_pressure_divisor_zero = r_out_dz;
    assign o_humidity_q22_10       = r_out_hum;

endmodule

### hdl/temp_press_hum_compensation_unit.sv
// ============================================================================
// temp_press_hum_compensation_unit
// Integer compensation of raw temperature, pressure and humidity samples.
// ============================================================================
// Usage:
//   Input side is a queue: drive a raw triple and raise i_push; the item is
//   taken at an edge where i_push is high and o_full is low.
//   Result side is a queue: while o_empty is low the oldest result is on the
//   o_ result ports; it is taken at an edge where i_pop is high.
//   Calibration is written through i_cfg_valid / i_cfg_index / i_cfg_data
//   (o_cfg_ready is always high); write it only while no item is in flight.
//   Throughput: one item per cycle while no result waits unpopped, set by the
//   pipelined back end whose pressure divider retires one quotient bit per
//   stage over 64 stages. Path: a taken item passes the input stage, the
//   queue, nine arithmetic stages, 66 divider stages, three stages and the
//   result register.
//   Stall: while a result waits unpopped the whole back end holds; the
//   four-entry queue and the input stage keep absorbing items until full.
//   Reset (i_rst_n low, synchronous) empties the block and clears all
//   calibration registers to zero.
// ============================================================================
module temp_press_hum_compensation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [19:0]                       i_raw_temperature,
    input  logic [19:0]                       i_raw_pressure,
    input  logic [15:0]                       i_raw_humidity,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic signed [31:0]                o_fine_temperature,
    output logic signed [31:0]                o_temperature_centi,
    output logic [31:0]                       o_pressure_q24_8,
    output logic                              o_pressure_divisor_zero,
    output logic [16:0]                       o_humidity_q22_10,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tphc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tphc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tphc_pkg::*;

    t_calib w_calib;
    t_item  w_q_in_item;
    t_item  w_q_out_item;
    logic   w_q_push;
    logic   w_q_full;
    logic   w_q_pop;
    logic   w_q_empty;

    // Front: registers and input stage
    tphc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_humidity    (i_raw_humidity),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_calib           (w_calib),
        .o_q_push          (w_q_push),
        .o_q_item          (w_q_in_item),
        .i_q_full          (w_q_full)
    );

    // Queue between front and back
    tphc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_out_item)
    );

    // Back: arithmetic pipeline
    tphc_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_calib                 (w_calib),
        .i_q_empty               (w_q_empty),
        .i_q_item                (w_q_out_item),
        .o_q_pop                 (w_q_pop),
        .i_pop                   (i_pop),
        .o_empty                 (o_empty),
        .o_fine_temperature      (o_fine_temperature),
        .o_temperature_centi     (o_temperature_centi),
        .o_pressure_q24_8        (o_pressure_q24_8),
        .o_pressure_divisor_zero (o_pressure_divisor_zero),
        .o_humidity_q22_10       (o_humidity_q22_10)
    );

    // Pressure is forced to zero with the divisor flag
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_pressure_divisor_zero) |-> (o_pressure_q24_8 == 32'd0))
        else $error("pressure not zero with divisor flag");

    // Humidity stays within the clamp range
    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_humidity_q22_10 <= 17'd102400))
        else $error("humidity above clamp");

    // Centi-degrees travel with their own fine temperature
    a_tc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_temperature_centi ==
            (((o_fine_temperature <<< 2) + o_fine_temperature + T_RND) >>> 8)))
        else $error("temperature out of step with fine temperature");

endmodule
